// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/wpso_pkg.sv -----
// Shared types and constants of the wavetable oscillator.
package wpso_pkg;

   localparam int DEF_TABLE_DEPTH     = 1024;
   localparam int DEF_SAMPLE_BITS     = 16;
   localparam int DEF_PHASE_FRAC_BITS = 16;

   localparam int CSR_ADDR_W = 5;
   localparam int INC_W      = 32;
   localparam int OUT_W      = 24;
   localparam int OUT_MAX    = 8388607;
   localparam int OUT_MIN    = -8388608;

   localparam logic [1:0] OP_SAMPLE    = 2'd0;
   localparam logic [1:0] OP_LOAD_MAIN = 2'd1;
   localparam logic [1:0] OP_LOAD_RAMP = 2'd2;

   localparam logic [25:0] RST_PULSE_WIDTH = 26'd33554432;
   localparam logic [25:0] RST_WIDTH_MIN   = 26'd3355443;
   localparam logic [25:0] RST_WIDTH_MAX   = 26'd63753420;
   localparam logic [15:0] RST_OUT_GAIN    = 16'd16384;
   localparam logic [19:0] RST_PITCH_SCALE = 20'd4096;

   typedef enum logic [2:0] {
      CSR_PULSE_WIDTH   = 3'd0,
      CSR_WIDTH_MIN     = 3'd1,
      CSR_WIDTH_MAX     = 3'd2,
      CSR_OUT_GAIN      = 3'd3,
      CSR_PITCH_SCALE   = 3'd4,
      CSR_SQUARE_ENABLE = 3'd5,
      CSR_SYNC_ENABLE   = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_SUM,
      ST_DIV, ST_SPH, ST_XF1, ST_XF2, ST_XF3, ST_GAIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic main_we;
      logic ramp_we;
   } tbl_we_type;

endpackage

// ----- design/wpso_tables.sv -----
// Main and ramp wavetable memories with registered read data.
module wpso_tables #(
   parameter int TABLE_DEPTH = wpso_pkg::DEF_TABLE_DEPTH,
   parameter int ENTRY_BITS  = 16
) (
   input  logic                           clock,
   input  wpso_pkg::tbl_we_type           we,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [ENTRY_BITS-1:0]          wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0] main_addr,
   input  logic [$clog2(TABLE_DEPTH)-1:0] ramp_addr,
   output logic [ENTRY_BITS-1:0]          main_q,
   output logic [ENTRY_BITS-1:0]          ramp_q
);
   import wpso_pkg::*;

   logic [ENTRY_BITS-1:0] main_mem [TABLE_DEPTH];
   logic [ENTRY_BITS-1:0] ramp_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (we.main_we) begin
         main_mem[wr_addr] <= wr_data;
      end
      main_q <= main_mem[main_addr];
   end

   always_ff @(posedge clock) begin
      if (we.ramp_we) begin
         ramp_mem[wr_addr] <= wr_data;
      end
      ramp_q <= ramp_mem[ramp_addr];
   end

endmodule

// ----- design/wpso_div.sv -----
// Restoring divider for the sync crossing fraction, one quotient bit a cycle.
module wpso_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   import wpso_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;

   assign shifted = {rem_ff, q_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign busy    = (cnt_ff != '0);
   assign quot    = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(NUM_W);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy) begin
         if (!diff[DEN_W]) begin
            rem_ff <= diff[DEN_W-1:0];
            q_ff   <= {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DEN_W-1:0];
            q_ff   <= {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

endmodule

// ----- design/wavetable_pwm_sync_oscillator.sv -----
// Top level of the wavetable oscillator with pulse width modulation and hard sync.
//
// Requests arrive on the req_ channel (valid/ready). A load request writes one
// entry of the main or ramp table and is taken with no response.
// A sample request returns one rsp_sample_out on the rsp_ channel (valid/ready).
// Without a sync event a sequencer makes six reads of the two table memories
// in states ST_RD0 to ST_RD3, interpolates with one shared multiplier and then
// scales by the gain. With a sync event the crossing fraction comes from a
// restoring divider of 16 + PHASE_FRAC_BITS steps, after which the waveform
// is formed a second time and crossfaded.
// Table depth must be a power of two; load addresses wrap to the depth.
// The configuration registers sit on the APB port at byte address 4 * index.
// Reset clears phase, pulse sign and the previous sync value and loads the
// registers with their defaults; table contents are undefined until loaded.
// A finished sample waits in the output register while rsp_ready is low; one
// more request may be accepted meanwhile, and its result waits until the
// output register is free.
module wavetable_pwm_sync_oscillator #(
   parameter int TABLE_DEPTH     = wpso_pkg::DEF_TABLE_DEPTH,
   parameter int SAMPLE_BITS     = wpso_pkg::DEF_SAMPLE_BITS,
   parameter int PHASE_FRAC_BITS = wpso_pkg::DEF_PHASE_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic signed [23:0]                req_rate_in,
   input  logic signed [25:0]                req_width_mod,
   input  logic signed [15:0]                req_sync_in,
   input  logic [9:0]                        req_table_addr,
   input  logic signed [15:0]                req_table_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [23:0]                rsp_sample_out,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wpso_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import wpso_pkg::*;

   `include "assert_macros.svh"

   localparam int F       = PHASE_FRAC_BITS;
   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int PHASE_W = IDX_W + F;
   localparam int EB      = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
   localparam int VW      = EB + 12;
   localparam int GW      = VW + 17;
   localparam int XW      = VW + F + 2;
   localparam int NUM_W   = 16 + F;
   localparam int DEN_W   = 17;
   localparam logic signed [GW-1:0] SAT_MAX = GW'(OUT_MAX);
   localparam logic signed [GW-1:0] SAT_MIN = GW'(OUT_MIN);
   localparam logic [F:0] X_ONE = (F + 1)'(1) << F;

   // Configuration registers.
   logic [25:0] pulse_width_ff, width_min_ff, width_max_ff;
   logic [15:0] out_gain_ff;
   logic [19:0] pitch_scale_ff;
   logic        square_enable_ff, sync_enable_ff;
   logic        csr_we;
   csr_index_type csr_idx;

   // Control state.
   state_type state_ff, state_in;
   logic [PHASE_W-1:0] phase_ff;
   logic               sign_ff;
   logic signed [15:0] last_sync_ff;
   logic               sync_ff, pass_ff, neg_ff;
   logic               rsp_valid_ff;
   logic               commit;
   logic               div_start;

   // Datapath registers.
   logic signed [23:0]    rate_ff;
   logic signed [25:0]    wmod_ff;
   logic signed [15:0]    sync_s_ff;
   logic signed [INC_W-1:0] inc_ff;
   logic [25:0]           w_ff;
   logic [PHASE_W-1:0]    p_ff;
   logic signed [EB-1:0]  ma_ff, ra_ff, rb_ff, ka_ff;
   logic signed [VW-1:0]  im_ff, ir_ff, ik_ff, mix_ff, post_ff;
   logic [F:0]            x_ff;
   logic signed [XW-1:0]  xa_ff, xb_ff;
   logic signed [GW-1:0]  gprod_ff;
   logic signed [23:0]    rsp_sample_ff;

   // Table interface.
   tbl_we_type          tbl_we;
   logic [IDX_W-1:0]    wr_addr, main_addr, ramp_addr;
   logic [EB-1:0]       main_q, ramp_q;

   // Divider interface.
   logic              div_busy;
   logic [NUM_W-1:0]  div_quot;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;

   // Combinational datapath.
   logic signed [44:0]        inc_prod;
   logic signed [27:0]        w_sum;
   logic [25:0]               w_clamped;
   logic [PHASE_W-1:0]        k_ph;
   logic [IDX_W-1:0]          p_idx, k_idx;
   logic signed [EB-1:0]      ia, ib;
   logic [F-1:0]              ifr;
   logic signed [EB:0]        idiff;
   logic signed [EB+F+1:0]    iprod;
   logic signed [VW-1:0]      ival;
   logic signed [VW-1:0]      rdiff, vterm, voice;
   logic signed [INC_W+F+1:0] sph_prod;
   logic signed [PHASE_W-1:0] inc_ext;
   logic signed [XW:0]        xsum;
   logic signed [GW-1:0]      oshift;
   logic signed [23:0]        osat;
   logic                      req_acc;
   logic                      sample_acc;

   assign pready    = 1'b1;
   assign csr_we    = psel && penable && pwrite;
   assign csr_idx   = csr_index_type'(paddr[4:2]);
   assign req_acc   = req_valid && req_ready;
   assign sample_acc = req_acc && (req_operation == OP_SAMPLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         CSR_PULSE_WIDTH:   prdata = 32'(pulse_width_ff);
         CSR_WIDTH_MIN:     prdata = 32'(width_min_ff);
         CSR_WIDTH_MAX:     prdata = 32'(width_max_ff);
         CSR_OUT_GAIN:      prdata = 32'(out_gain_ff);
         CSR_PITCH_SCALE:   prdata = 32'(pitch_scale_ff);
         CSR_SQUARE_ENABLE: prdata = 32'(square_enable_ff);
         CSR_SYNC_ENABLE:   prdata = 32'(sync_enable_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff   <= RST_PULSE_WIDTH;
         width_min_ff     <= RST_WIDTH_MIN;
         width_max_ff     <= RST_WIDTH_MAX;
         out_gain_ff      <= RST_OUT_GAIN;
         pitch_scale_ff   <= RST_PITCH_SCALE;
         square_enable_ff <= 1'b0;
         sync_enable_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_PULSE_WIDTH:   pulse_width_ff   <= pwdata[25:0];
            CSR_WIDTH_MIN:     width_min_ff     <= pwdata[25:0];
            CSR_WIDTH_MAX:     width_max_ff     <= pwdata[25:0];
            CSR_OUT_GAIN:      out_gain_ff      <= pwdata[15:0];
            CSR_PITCH_SCALE:   pitch_scale_ff   <= pwdata[19:0];
            CSR_SQUARE_ENABLE: square_enable_ff <= pwdata[0];
            CSR_SYNC_ENABLE:   sync_enable_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Table loads are written straight from the request.
   assign tbl_we.main_we = req_acc && (req_operation == OP_LOAD_MAIN);
   assign tbl_we.ramp_we = req_acc && (req_operation == OP_LOAD_RAMP);
   assign wr_addr = IDX_W'(req_table_addr);

   assign k_ph  = p_ff + PHASE_W'(w_ff);
   assign p_idx = p_ff[PHASE_W-1:F];
   assign k_idx = k_ph[PHASE_W-1:F];

   always_comb begin
      main_addr = p_idx;
      ramp_addr = p_idx;
      priority case (state_ff)
         ST_RD1: begin
            main_addr = p_idx + 1'b1;
            ramp_addr = p_idx + 1'b1;
         end
         ST_RD2:  ramp_addr = k_idx;
         ST_RD3:  ramp_addr = k_idx + 1'b1;
         default: ;
      endcase
   end

   wpso_tables #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ENTRY_BITS  (EB)
   ) u_tables (
      .clock     (clock),
      .we        (tbl_we),
      .wr_addr   (wr_addr),
      .wr_data   (EB'(req_table_data)),
      .main_addr (main_addr),
      .ramp_addr (ramp_addr),
      .main_q    (main_q),
      .ramp_q    (ramp_q)
   );

   assign div_num = {sync_s_ff, F'(0)};
   assign div_den = {sync_s_ff[15], sync_s_ff} - {last_sync_ff[15], last_sync_ff};

   wpso_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // Increment and clamped pulse width.
   assign inc_prod = rate_ff * $signed({1'b0, pitch_scale_ff});
   assign w_sum    = $signed({2'b00, pulse_width_ff}) + $signed({{2{wmod_ff[25]}}, wmod_ff});

   always_comb begin
      if (w_sum < $signed({2'b00, width_min_ff})) begin
         w_clamped = width_min_ff;
      end else if (w_sum > $signed({2'b00, width_max_ff})) begin
         w_clamped = width_max_ff;
      end else begin
         w_clamped = w_sum[25:0];
      end
   end

   // Shared interpolation unit: one multiply per cycle.
   always_comb begin
      ia  = ma_ff;
      ib  = $signed(main_q);
      ifr = p_ff[F-1:0];
      priority case (state_ff)
         ST_RD3: begin
            ia = ra_ff;
            ib = rb_ff;
         end
         ST_RD4: begin
            ia  = ka_ff;
            ib  = $signed(ramp_q);
            ifr = k_ph[F-1:0];
         end
         default: ;
      endcase
   end

   assign idiff = {ib[EB-1], ib} - {ia[EB-1], ia};
   assign iprod = idiff * $signed({1'b0, ifr});
   assign ival  = (VW'(ia) <<< 8) + VW'(iprod >>> (F - 8));

   assign rdiff = ir_ff - ik_ff;
   assign vterm = !square_enable_ff ? '0 : (neg_ff ? -rdiff : rdiff);
   assign voice = im_ff + vterm;

   assign sph_prod = inc_ff * $signed({1'b0, x_ff});
   assign inc_ext  = PHASE_W'(inc_ff);
   assign xsum     = {xa_ff[XW-1], xa_ff} + {xb_ff[XW-1], xb_ff};
   assign oshift   = gprod_ff >>> (SAMPLE_BITS - 2);

   always_comb begin
      if (oshift > SAT_MAX) begin
         osat = 24'(SAT_MAX);
      end else if (oshift < SAT_MIN) begin
         osat = 24'(SAT_MIN);
      end else begin
         osat = 24'(oshift);
      end
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_operation == OP_SAMPLE)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            div_start = sync_enable_ff && last_sync_ff[15] && !sync_s_ff[15];
            state_in  = ST_RD0;
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: state_in = ST_RD2;
         ST_RD2: state_in = ST_RD3;
         ST_RD3: state_in = ST_RD4;
         ST_RD4: state_in = ST_SUM;
         ST_SUM: begin
            if (pass_ff) begin
               state_in = ST_XF1;
            end else if (sync_ff) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_GAIN;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_SPH;
            end
         end
         ST_SPH:  state_in = ST_RD0;
         ST_XF1:  state_in = ST_XF2;
         ST_XF2:  state_in = ST_XF3;
         ST_XF3:  state_in = ST_GAIN;
         ST_GAIN: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         sign_ff      <= 1'b0;
         last_sync_ff <= '0;
         sync_ff      <= 1'b0;
         pass_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_PREP) begin
            sync_ff <= div_start;
            pass_ff <= 1'b0;
            neg_ff  <= sign_ff;
         end
         if (state_ff == ST_SPH) begin
            pass_ff <= 1'b1;
            neg_ff  <= !sign_ff;
         end
         if (commit) begin
            phase_ff     <= sync_ff ? p_ff : phase_ff + $unsigned(inc_ext);
            sign_ff      <= sign_ff ^ sync_ff;
            last_sync_ff <= sync_s_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rate_ff   <= req_rate_in;
         wmod_ff   <= req_width_mod;
         sync_s_ff <= req_sync_in;
      end
      unique case (state_ff)
         ST_PREP: begin
            inc_ff <= INC_W'(inc_prod >>> 12);
            w_ff   <= w_clamped;
            p_ff   <= phase_ff;
         end
         ST_RD1: begin
            ma_ff <= $signed(main_q);
            ra_ff <= $signed(ramp_q);
         end
         ST_RD2: begin
            im_ff <= ival;
            rb_ff <= $signed(ramp_q);
         end
         ST_RD3: begin
            ir_ff <= ival;
            ka_ff <= $signed(ramp_q);
         end
         ST_RD4: ik_ff <= ival;
         ST_SUM: begin
            if (pass_ff) begin
               post_ff <= voice;
            end else begin
               mix_ff <= voice;
            end
         end
         ST_DIV: x_ff <= div_quot[F:0];
         ST_SPH: p_ff <= PHASE_W'(sph_prod >>> F);
         ST_XF1: xa_ff <= mix_ff * $signed({1'b0, X_ONE - x_ff});
         ST_XF2: xb_ff <= post_ff * $signed({1'b0, x_ff});
         ST_XF3: mix_ff <= VW'(xsum >>> F);
         ST_GAIN: gprod_ff <= mix_ff * $signed({1'b0, out_gain_ff});
         ST_OUT: begin
            if (commit) begin
               rsp_sample_ff <= osat;
            end
         end
         default: ;
      endcase
   end

   `ASSERT_ALWAYS(a_div_only_on_sync, clock, reset, !div_busy || sync_ff, "divider without sync")
   `ASSERT_NEXT(a_sample_blocks_accept, clock, reset, sample_acc, !req_ready, "accept while busy")
   `ASSERT_NEXT(a_phase_only_at_commit, clock, reset, !commit, $stable(phase_ff), "phase moved")

endmodule
